// ===== src/pfe_pkg.sv =====
// pfe_pkg: shared types, constants and command structs for the postfix evaluator
// depends on nothing
`timescale 1ns / 1ps
package pfe_pkg;
	localparam int STACK_DEPTH = 64;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_MUL   = 8'h2a;
	localparam logic [7:0] CH_DIV   = 8'h2f;
	localparam logic [7:0] CH_POW   = 8'h5e;

	localparam logic [2:0] ST_VALID = 3'd0;
	localparam logic [2:0] ST_COUNT = 3'd1;
	localparam logic [2:0] ST_UNDER = 3'd2;
	localparam logic [2:0] ST_OVER  = 3'd3;
	localparam logic [2:0] ST_DIVZ  = 3'd4;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_POW = 3'd4;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_expr;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} out_beat_t;

	typedef struct packed {
		logic       push;
		logic       rd_ops;
		logic       start;
		logic [2:0] op;
		logic       wr_res;
		logic       rd_top;
		logic       clear;
	} pfe_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic divz;
	} pfe_sts_t;
endpackage

// ===== src/pfe_alu.sv =====
// pfe_alu: iterative arithmetic unit, add/sub/mul on start, divide by shift-subtract and power by square-and-multiply
// depends on pfe_pkg
`timescale 1ns / 1ps
module pfe_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  op,
	input  logic [31:0] lhs,
	input  logic [31:0] rhs,
	output logic [31:0] result,
	output pfe_pkg::pfe_sts_t sts
);
	import pfe_pkg::*;

	logic        busy_q, done_q;
	logic [2:0]  op_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q, b_q, r_q, acc_q;
	logic        neg_q;
	logic [32:0] trial;
	logic [31:0] lm, rm, rem_sh, q_next;

	assign lm = lhs[31] ? 32'd0 - lhs : lhs;
	assign rm = rhs[31] ? 32'd0 - rhs : rhs;
	assign rem_sh = {r_q[30:0], a_q[31]};
	assign trial = {1'b0, rem_sh} - {1'b0, b_q};
	assign q_next = {acc_q[30:0], ~trial[32]};

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.divz = (rhs == 32'd0);
	assign result = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q <= op;
				cnt_q <= '0;
				unique case (op)
					OP_ADD: begin acc_q <= lhs + rhs; done_q <= 1'b1; end
					OP_SUB: begin acc_q <= lhs - rhs; done_q <= 1'b1; end
					OP_MUL: begin acc_q <= lhs * rhs; done_q <= 1'b1; end
					OP_DIV: begin
						a_q <= lm; b_q <= rm; r_q <= '0; acc_q <= '0;
						neg_q <= lhs[31] ^ rhs[31];
						busy_q <= 1'b1;
					end
					OP_POW: begin
						if (rhs[31]) begin
							if (lhs == 32'd1) acc_q <= 32'd1;
							else if (lhs == 32'hffffffff)
								acc_q <= rhs[0] ? 32'hffffffff : 32'd1;
							else acc_q <= 32'd0;
							done_q <= 1'b1;
						end else begin
							a_q <= lhs; b_q <= rhs; acc_q <= 32'd1;
							busy_q <= 1'b1;
						end
					end
					default: begin acc_q <= '0; done_q <= 1'b1; end
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (op_q == OP_DIV) begin
					a_q <= {a_q[30:0], 1'b0};
					if (!trial[32]) r_q <= trial[31:0];
					else r_q <= rem_sh;
					if (cnt_q == 6'd31) begin
						busy_q <= 1'b0;
						acc_q <= neg_q ? 32'd0 - q_next : q_next;
					end else begin
						acc_q <= q_next;
					end
				end else begin
					if (b_q[0]) acc_q <= acc_q * a_q;
					a_q <= a_q * a_q;
					b_q <= {1'b0, b_q[31:1]};
					if (cnt_q == 6'd30) busy_q <= 1'b0;
				end
				if ((op_q == OP_DIV && cnt_q == 6'd31) || (op_q != OP_DIV && cnt_q == 6'd30))
					done_q <= 1'b1;
			end
		end
	end
endmodule

// ===== src/pfe_datapath.sv =====
// pfe_datapath: operand stack memory, stack count, error register and output register
// depends on pfe_pkg, pfe_alu
`timescale 1ns / 1ps
module pfe_datapath (
	input  logic        clk,
	input  logic        arst_n,
	input  pfe_pkg::pfe_cmd_t cmd,
	input  logic [7:0]  char_code,
	output logic [pfe_pkg::CNT_W-1:0] count,
	output logic [2:0]  err,
	output pfe_pkg::pfe_sts_t sts,
	output logic [31:0] top,
	output logic [31:0] value_q
);
	import pfe_pkg::*;

	logic [31:0] mem [STACK_DEPTH];
	logic [CNT_W-1:0] cnt_q;
	logic [2:0]  err_q;
	logic [31:0] rd_r_q, rd_l_q, alu_res;
	logic [PTR_W-1:0] pr, pl;

	assign pr = PTR_W'(cnt_q - CNT_W'(1));
	assign pl = PTR_W'(cnt_q - CNT_W'(2));
	assign count = cnt_q;
	assign err = err_q;
	assign top = rd_r_q;

	pfe_alu u_alu (
		.clk(clk), .arst_n(arst_n), .start(cmd.start), .op(cmd.op),
		.lhs(rd_l_q), .rhs(rd_r_q), .result(alu_res), .sts(sts)
	);

	always_ff @(posedge clk) begin
		if (cmd.push) mem[cnt_q[PTR_W-1:0]] <= {28'd0, char_code[3:0] - 4'd0};
		else if (cmd.wr_res) mem[pl] <= alu_res;
		if (cmd.rd_ops || cmd.rd_top) begin
			rd_r_q <= mem[pr];
			rd_l_q <= mem[pl];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			err_q <= ST_VALID;
		end else if (cmd.clear) begin
			cnt_q <= '0;
			err_q <= ST_VALID;
		end else if (cmd.push) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.wr_res) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cmd.op == OP_DIV && cmd.start && sts.divz) begin
			err_q <= ST_DIVZ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_top) value_q <= (cnt_q != '0) ? mem[pr] : 32'd0;
	end
	logic unused;
	assign unused = ^{char_code[7:4]};
endmodule

// ===== src/pfe_ctrl.sv =====
// pfe_ctrl: controller state machine, decodes characters and sequences the datapath
// depends on pfe_pkg
`timescale 1ns / 1ps
module pfe_ctrl (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pfe_pkg::in_beat_t in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  out_status,
	input  logic [pfe_pkg::CNT_W-1:0] count,
	input  logic [2:0]  err,
	input  pfe_pkg::pfe_sts_t sts,
	output pfe_pkg::pfe_cmd_t cmd,
	output logic        over_err,
	output logic        under_err
);
	import pfe_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_READ = 3'd1;
	localparam logic [2:0] S_RUN  = 3'd2;
	localparam logic [2:0] S_TOP  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic       last_q, out_v_q;
	logic [2:0] op_q, st_q, err_q;
	logic       is_dig, is_op;
	logic [2:0] dec_op;

	always_comb begin
		dec_op = OP_ADD;
		is_op = 1'b1;
		unique case (in_data.char_code)
			CH_PLUS:  dec_op = OP_ADD;
			CH_MINUS: dec_op = OP_SUB;
			CH_MUL:   dec_op = OP_MUL;
			CH_DIV:   dec_op = OP_DIV;
			CH_POW:   dec_op = OP_POW;
			default:  is_op = 1'b0;
		endcase
	end
	assign is_dig = in_data.char_code >= CH_ZERO && in_data.char_code <= CH_NINE;

	assign in_ready = (state_q == S_IDLE) && !out_v_q;
	assign out_valid = out_v_q;
	assign out_status = st_q;
	logic acc;
	assign acc = in_valid && in_ready;
	logic e_any;
	assign e_any = (err_q != ST_VALID);
	assign over_err = acc && !e_any && is_dig && count >= CNT_W'(STACK_DEPTH);
	assign under_err = acc && !e_any && is_op && count < CNT_W'(2);

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc && !e_any && is_dig && !over_err) cmd.push = 1'b1;
				if (acc && !e_any && is_op && !under_err) cmd.rd_ops = 1'b1;
				if (acc && !(!e_any && is_op && !under_err) && in_data.end_of_expr)
					cmd.rd_top = !(is_dig && !over_err && !e_any);
			end
			S_READ: begin
				cmd.start = !(op_q == OP_DIV && sts.divz);
			end
			S_RUN: cmd.wr_res = sts.done;
			S_TOP: cmd.rd_top = 1'b1;
			S_OUT: cmd.clear = 1'b0;
			default: cmd = '0;
		endcase
		if (out_v_q && out_ready) cmd.clear = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_v_q <= 1'b0;
			last_q  <= 1'b0;
			err_q   <= ST_VALID;
			op_q    <= OP_ADD;
			st_q    <= ST_VALID;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
				err_q <= ST_VALID;
			end
			unique case (state_q)
				S_IDLE: if (acc) begin
					last_q <= in_data.end_of_expr;
					if (over_err) err_q <= ST_OVER;
					if (under_err) err_q <= ST_UNDER;
					if (!e_any && is_op && !under_err) begin
						op_q <= dec_op;
						state_q <= S_READ;
					end else if (in_data.end_of_expr) begin
						state_q <= S_TOP;
					end
				end
				S_READ: begin
					if (op_q == OP_DIV && sts.divz) begin
						err_q <= ST_DIVZ;
						state_q <= last_q ? S_TOP : S_IDLE;
					end else state_q <= S_RUN;
				end
				S_RUN: if (sts.done) state_q <= last_q ? S_TOP : S_IDLE;
				S_TOP: state_q <= S_OUT;
				S_OUT: begin
					out_v_q <= 1'b1;
					if (e_any) st_q <= err_q;
					else if (count != CNT_W'(1)) st_q <= ST_COUNT;
					else st_q <= ST_VALID;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
	logic unused;
	assign unused = ^{err, sts.busy};
endmodule

// ===== src/postfix_expression_evaluator.sv =====
// postfix_expression_evaluator: top level, joins controller and datapath
// depends on pfe_pkg, pfe_ctrl, pfe_datapath
//
// channel  direction  payload     handshake
// in       input      in_beat_t   in_valid / in_ready
// out      output     out_beat_t  out_valid / out_ready
//
// digit: pushed onto the stack; ignored character: skipped; add, sub, mul: operand read, arithmetic, write-back
// divide and power: operand read, then the shift-subtract
// and square-and-multiply loops of the arithmetic unit, then write-back; divide by zero: error, no write-back
// last character also reads the stack top; input stalls until the result beat is taken
// reset clears count, error and control; stack contents stay undefined
`timescale 1ns / 1ps
module postfix_expression_evaluator (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  pfe_pkg::in_beat_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output pfe_pkg::out_beat_t out_data
);
	import pfe_pkg::*;

	pfe_cmd_t cmd, cmd_c;
	pfe_sts_t sts;
	logic [CNT_W-1:0] count;
	logic [2:0] err, status;
	logic [31:0] top, value;
	logic over_err, under_err;

	pfe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
		.out_status(status), .count(count), .err(err), .sts(sts), .cmd(cmd_c),
		.over_err(over_err), .under_err(under_err)
	);

	always_comb begin
		cmd = cmd_c;
	end

	pfe_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .char_code(in_data.char_code),
		.count(count), .err(err), .sts(sts), .top(top), .value_q(value)
	);

	assign out_data.value = value;
	assign out_data.status = status;
	logic unused;
	assign unused = ^{top, over_err, under_err};
endmodule

// ===== tb/postfix_expression_evaluator_tb.sv =====
// postfix_expression_evaluator_tb: self-checking bench for the postfix evaluator
// drives character beats, predicts value and status per expression, checks result beats
// depends on pfe_pkg and postfix_expression_evaluator
`timescale 1ns / 1ps
module postfix_expression_evaluator_tb;
	import pfe_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;
	logic in_ready_seen;

	postfix_expression_evaluator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	in_beat_t pending_chars[$];
	out_beat_t expected_results[$];

	logic [31:0] eval_stack[STACK_DEPTH];
	int unsigned eval_count;
	logic [2:0] eval_error;

	int mismatches;
	int idle_cycles;
	bit stim_done;
	bit calm;
	bit hold_off;
	int hold_len;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] trunc_div(logic [31:0] l, logic [31:0] r);
		logic [31:0] lm, rm, q;
		lm = l[31] ? -l : l;
		rm = r[31] ? -r : r;
		q = lm / rm;
		return (l[31] != r[31]) ? -q : q;
	endfunction

	function automatic logic [31:0] wrap_pow(logic [31:0] b, logic [31:0] e);
		logic [31:0] acc;
		acc = 32'd1;
		if (e[31]) begin
			if (b == 32'd1) return 32'd1;
			if (b == 32'hffffffff) return e[0] ? 32'hffffffff : 32'd1;
			return 32'd0;
		end
		while (e != 0) begin
			if (e[0]) acc = acc * b;
			b = b * b;
			e = e >> 1;
		end
		return acc;
	endfunction

	task automatic evaluate_char(input in_beat_t beat);
		logic [31:0] l, r, res;
		out_beat_t o;
		logic [7:0] c;
		c = beat.char_code;
		if (eval_error == ST_VALID) begin
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (eval_count >= STACK_DEPTH) eval_error = ST_OVER;
				else begin
					eval_stack[eval_count] = {24'd0, c - CH_ZERO};
					eval_count++;
				end
			end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL
					|| c == CH_DIV || c == CH_POW) begin
				if (eval_count < 2) eval_error = ST_UNDER;
				else begin
					r = eval_stack[eval_count - 1];
					l = eval_stack[eval_count - 2];
					res = 32'd0;
					case (c)
						CH_PLUS: res = l + r;
						CH_MINUS: res = l - r;
						CH_MUL: res = l * r;
						CH_DIV: if (r != 0) res = trunc_div(l, r);
						default: res = wrap_pow(l, r);
					endcase
					if (c == CH_DIV && r == 0) eval_error = ST_DIVZ;
					else begin
						eval_stack[eval_count - 2] = res;
						eval_count--;
					end
				end
			end
		end
		if (beat.end_of_expr) begin
			o.value = (eval_count > 0) ? eval_stack[eval_count - 1] : 32'd0;
			if (eval_error != ST_VALID) o.status = eval_error;
			else if (eval_count != 1) o.status = ST_COUNT;
			else o.status = ST_VALID;
			expected_results.push_back(o);
			eval_count = 0;
			eval_error = ST_VALID;
		end
	endtask

	task automatic add_expr(input string s);
		in_beat_t b;
		for (int i = 0; i < s.len(); i++) begin
			b.char_code = s[i];
			b.end_of_expr = (i == s.len() - 1);
			pending_chars.push_back(b);
		end
	endtask

	function automatic logic [7:0] pick_op();
		case ($urandom_range(4))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_MUL;
			3: return CH_DIV;
			default: return CH_POW;
		endcase
	endfunction

	function automatic logic [7:0] pick_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	// well-formed expression with random content, sometimes spoilt
	task automatic add_random_expr();
		string s;
		int depth, n;
		s = "";
		depth = 0;
		n = $urandom_range(1, 12);
		for (int i = 0; i < n; i++) begin
			if (depth >= 2 && $urandom_range(1)) begin
				s = {s, string'(pick_op())};
				depth--;
			end else begin
				s = {s, string'(pick_digit())};
				depth++;
			end
			if ($urandom_range(9) == 0) s = {s, string'(8'($urandom_range(255)))};
		end
		while (depth > 1 && $urandom_range(3) != 0) begin
			s = {s, string'(pick_op())};
			depth--;
		end
		if ($urandom_range(9) == 0) s = {s, string'(pick_op())};
		add_expr(s);
	endtask

	initial begin
		string s;
		in_beat_t b;
		add_expr("34+");
		add_expr("92-");
		add_expr("78*");
		add_expr("93/");
		add_expr("23^");
		add_expr("00^");
		add_expr("50/");
		add_expr("+");
		add_expr("12");
		add_expr("a");
		add_expr("01-2^");
		add_expr("101-^");
		add_expr("101-9-^");
		add_expr("201-^");
		add_expr("7 0-2/");
		add_expr("09-2/");
		add_expr("99*9*9*9*9*9*9*9*9*9*");
		add_expr("01-91-/");
		add_expr("29^9^");
		s = "";
		for (int i = 0; i < STACK_DEPTH; i++) s = {s, "1"};
		add_expr(s);
		add_expr({s, "1"});
		b.char_code = 8'hff; b.end_of_expr = 1'b1; pending_chars.push_back(b);
		b.char_code = 8'h00; b.end_of_expr = 1'b1; pending_chars.push_back(b);
		// most negative over minus one
		add_expr("239*4+^01-/");
		while (pending_chars.size() < 520) add_random_expr();
		// every 17th char code, with end flag toggling
		for (int i = 0; i < 256; i += 17) begin
			b.char_code = 8'(i); b.end_of_expr = i[0]; pending_chars.push_back(b);
		end
		b.char_code = 8'h01; b.end_of_expr = 1'b1; pending_chars.push_back(b);
	end

	initial begin
		arst_n = 1'b0;
		eval_count = 0;
		eval_error = ST_VALID;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver
	initial begin
		in_valid = 1'b0;
		in_data = '0;
		stim_done = 1'b0;
	end

	initial in_ready_seen = 1'b0;

	always @(negedge clk) begin
		int cyc;
		if (arst_n) begin
			cyc++;
			calm <= (cyc > 2000 && cyc < 4000);
			if (!in_valid || in_ready_seen) begin
				if (pending_chars.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
					in_valid <= 1'b1;
					in_data <= pending_chars.pop_front();
				end else begin
					in_valid <= 1'b0;
					if (pending_chars.size() == 0) stim_done <= 1'b1;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		out_beat_t exp_beat;
		in_ready_seen <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (in_valid && in_ready) begin
				evaluate_char(in_data);
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result beat value=%0d status=%0d",
						out_data.value, out_data.status);
				end else begin
					exp_beat = expected_results.pop_front();
					if (out_data.value !== exp_beat.value || out_data.status !== exp_beat.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected value=%0d status=%0d, got value=%0d status=%0d",
								exp_beat.value, exp_beat.status, out_data.value, out_data.status);
					end
				end
			end
		end
	end

	// receiver, with one long hold-off
	initial begin
		out_ready = 1'b0;
		hold_off = 1'b0;
		hold_len = 0;
	end

	always @(negedge clk) begin
		int rcyc;
		if (arst_n) begin
			rcyc++;
			if (rcyc == 600) begin
				hold_off <= 1'b1;
				hold_len <= 0;
			end else if (hold_off) begin
				hold_len <= hold_len + 1;
				if (hold_len >= 400) hold_off <= 1'b0;
			end
			if (hold_off) out_ready <= 1'b0;
			else out_ready <= calm || ($urandom_range(99) >= 16);
		end
	end

	initial begin
		idle_cycles = 0;
		mismatches = 0;
		wait (arst_n);
		while (!(stim_done && expected_results.size() == 0 && !in_valid)) begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
src/pfe_pkg.sv
src/pfe_alu.sv
src/pfe_datapath.sv
src/pfe_ctrl.sv
src/postfix_expression_evaluator.sv
tb/postfix_expression_evaluator_tb.sv
